// File: src/sor_pkg.sv
// package for the spiral order matrix reorder block
// sizes, store geometry and the control enums; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sor_pkg;

  localparam int MAX_DIM = 8;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = ADDR_W + 1;
  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int DIM_W = 4;
  localparam int VALUE_W = 32;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } dir_t;

endpackage

`default_nettype wire

// File: src/sor_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sor_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/spiral_order_matrix_reorder.sv
// top level of the spiral order matrix reorder block
// uses sor_pkg and one sor_ram instance for the matrix store
//
// usage:
//   the size register (rows = columns, 1..8; 0 acts as 1, above 8 as 8) is
//   written over cfg_valid/cfg_ready/cfg_data; cfg_ready is high while busy and
//   start are both low, and every write restarts loading of the matrix.
//   elements arrive in row-major order: one item is taken at each clock edge
//   with start high and busy low. the item that completes the n*n matrix
//   raises busy while the store is walked in clockwise spiral order, one read
//   a cycle. each result shows on out_value with out_valid high for one cycle,
//   in the cycle after its store read; out_last marks the final one. the first
//   result is on the ports once the state register has entered emit and the
//   store read has been registered. loading and emitting do not overlap: no
//   item is taken while busy is high.
//   the receiver cannot stall; results are not held.
//   reset (rst, synchronous) sets the size to 8 and the load count to zero;
//   the store is not cleared, only entries written in the current load are read.
`timescale 1ns / 1ps
`default_nettype none

module spiral_order_matrix_reorder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic signed [sor_pkg::VALUE_W-1:0] element_value,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [sor_pkg::DIM_W-1:0]     cfg_data,
  output      logic                          out_valid,
  output      logic signed [sor_pkg::VALUE_W-1:0] out_value,
  output      logic                          out_last
);

  import sor_pkg::*;

  state_t            state, state_next;
  dir_t              dir, dir_next;
  logic [DIM_W-1:0]  matrix_size;
  logic [CNT_W-1:0]  load_count, load_count_next;
  logic [CNT_W-1:0]  emit_count, emit_count_next;
  logic [IDX_W-1:0]  row, row_next;
  logic [IDX_W-1:0]  col, col_next;
  logic [IDX_W-1:0]  edge_lo, edge_lo_next;
  logic [IDX_W-1:0]  edge_hi, edge_hi_next;

  logic [DIM_W-1:0]  dim;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  load_index;
  logic              load_take;
  logic              cfg_take;
  logic              rd_en;
  logic              rd_last;
  logic [ADDR_W-1:0] rd_addr;
  logic [VALUE_W-1:0] rd_data;

  // effective size
  always_comb begin
    if (matrix_size == '0) begin
      dim = DIM_W'(1);
    end else if (matrix_size > DIM_W'(MAX_DIM)) begin
      dim = DIM_W'(MAX_DIM);
    end else begin
      dim = matrix_size;
    end
  end

  assign total      = CNT_W'(CNT_W'(dim) * CNT_W'(dim));
  assign busy       = (state == ST_EMIT);
  assign cfg_ready  = !busy && !start;
  assign cfg_take   = cfg_valid && cfg_ready;
  assign load_take  = start && !busy;
  assign load_index = (load_count >= total) ? '0 : load_count;
  assign rd_en      = (state == ST_EMIT);
  assign rd_last    = (emit_count == total - CNT_W'(1));
  assign rd_addr    = ADDR_W'(CNT_W'(CNT_W'(row) * CNT_W'(dim)) + CNT_W'(col));

  always_comb begin
    state_next      = state;
    dir_next        = dir;
    load_count_next = load_count;
    emit_count_next = emit_count;
    row_next        = row;
    col_next        = col;
    edge_lo_next    = edge_lo;
    edge_hi_next    = edge_hi;
    unique case (state)
      ST_LOAD: begin
        if (cfg_take) begin
          load_count_next = '0;
        end else if (load_take) begin
          if (load_index + CNT_W'(1) == total) begin
            load_count_next = '0;
            state_next      = ST_EMIT;
            emit_count_next = '0;
            dir_next        = DIR_RIGHT;
            row_next        = '0;
            col_next        = '0;
            edge_lo_next    = '0;
            edge_hi_next    = IDX_W'(dim - DIM_W'(1));
          end else begin
            load_count_next = load_index + CNT_W'(1);
          end
        end
      end
      ST_EMIT: begin
        emit_count_next = emit_count + CNT_W'(1);
        if (rd_last) begin
          state_next = ST_LOAD;
        end
        unique case (dir)
          DIR_RIGHT: begin
            if (col < edge_hi) begin
              col_next = col + IDX_W'(1);
            end else begin
              row_next = row + IDX_W'(1);
              dir_next = DIR_DOWN;
            end
          end
          DIR_DOWN: begin
            if (row < edge_hi) begin
              row_next = row + IDX_W'(1);
            end else begin
              col_next = col - IDX_W'(1);
              dir_next = DIR_LEFT;
            end
          end
          DIR_LEFT: begin
            if (col > edge_lo) begin
              col_next = col - IDX_W'(1);
            end else begin
              row_next = row - IDX_W'(1);
              dir_next = DIR_UP;
            end
          end
          DIR_UP: begin
            if (row > edge_lo + IDX_W'(1)) begin
              row_next = row - IDX_W'(1);
            end else begin
              // step into the next ring
              edge_lo_next = edge_lo + IDX_W'(1);
              edge_hi_next = edge_hi - IDX_W'(1);
              row_next     = edge_lo + IDX_W'(1);
              col_next     = edge_lo + IDX_W'(1);
              dir_next     = DIR_RIGHT;
            end
          end
          default: begin
            dir_next = DIR_RIGHT;
          end
        endcase
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      matrix_size <= DIM_W'(MAX_DIM);
      load_count  <= '0;
      out_valid   <= 1'b0;
      out_last    <= 1'b0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      out_valid  <= rd_en;
      out_last   <= rd_en && rd_last;
      if (cfg_take) begin
        matrix_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    dir        <= dir_next;
    emit_count <= emit_count_next;
    row        <= row_next;
    col        <= col_next;
    edge_lo    <= edge_lo_next;
    edge_hi    <= edge_hi_next;
  end

  sor_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (load_take),
    .waddr (load_index[ADDR_W-1:0]),
    .wdata (element_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign out_value = rd_data;

endmodule

`default_nettype wire
